// ===== rtl/gflr_pkg.sv =====
// gflr_pkg: shared types, constants and field tables for the gf(256) recombine block
// no dependencies; imported by gflr_unit and the top level
package gflr_pkg;

	// field polynomial and multiplicative group order
	localparam logic [8:0] GF_POLY  = 9'h11d;
	localparam logic [8:0] GF_ORDER = 9'd255;

	// fixed field widths
	localparam int SLOT_CNT_W = 5;
	localparam int SIZE_W     = 6;
	localparam int INDEX_W    = 5;

	// configuration register indexes
	localparam logic CFG_SLOT_COUNT  = 1'b0;
	localparam logic CFG_SECRET_SIZE = 1'b1;

	typedef logic [7:0] gf_tbl_t [256];

	// log table, log of zero reads as zero
	function automatic gf_tbl_t gf_log_build();
		gf_tbl_t    t;
		logic [8:0] x;
		int         n;
		t = '{default: 8'h00};
		x = 9'h001;
		for (n = 0; n < 255; n++) begin
			t[x[7:0]] = 8'(n);
			x = {x[7:0], 1'b0};
			if (x[8]) begin
				x = x ^ GF_POLY;
			end
		end
		return t;
	endfunction

	// antilog table, last entry is never addressed
	function automatic gf_tbl_t gf_exp_build();
		gf_tbl_t    t;
		logic [8:0] x;
		int         n;
		t = '{default: 8'h01};
		x = 9'h001;
		for (n = 0; n < 255; n++) begin
			t[n] = x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8]) begin
				x = x ^ GF_POLY;
			end
		end
		return t;
	endfunction

	localparam gf_tbl_t GF_LOG = gf_log_build();
	localparam gf_tbl_t GF_EXP = gf_exp_build();

	// operations of the shared log-domain unit
	typedef enum logic [2:0] {
		UOP_PAIR = 3'b001,
		UOP_DIFF = 3'b010,
		UOP_MUL  = 3'b100
	} unit_op_t;

	typedef struct packed {
		unit_op_t   op;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] x;
		logic [7:0] y;
	} unit_req_t;

	typedef struct packed {
		logic [7:0] r0;
		logic [7:0] r1;
	} unit_rsp_t;

endpackage

// ===== rtl/gflr_ram.sv =====
// gflr_ram: generic single write port, single read port ram with registered read
// no dependencies
module gflr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/gflr_unit.sv =====
// gflr_unit: shared log-domain arithmetic unit, sums and differences of logs modulo 255
// depends on gflr_pkg (log table, request and response types)
module gflr_unit import gflr_pkg::*; (
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	// one compare and subtract brings a sum below twice the order back in range
	function automatic logic [7:0] mod255(input logic [8:0] s);
		return (s >= GF_ORDER) ? 8'(s - GF_ORDER) : s[7:0];
	endfunction

	logic [8:0] sum0;
	logic [8:0] sum1;

	// operand selection per operation
	always_comb begin
		case (req.op)
			UOP_PAIR: begin
				sum0 = {1'b0, req.a} + {1'b0, GF_LOG[req.x]};
				sum1 = {1'b0, req.b} + {1'b0, GF_LOG[req.y]};
			end
			UOP_DIFF: begin
				sum0 = {1'b0, req.a} + GF_ORDER - {1'b0, req.b};
				sum1 = 9'h000;
			end
			UOP_MUL: begin
				sum0 = {1'b0, req.a} + {1'b0, GF_LOG[req.x]};
				sum1 = 9'h000;
			end
			default: begin
				sum0 = 9'h000;
				sum1 = 9'h000;
			end
		endcase
	end

	assign rsp.r0 = mod255(sum0);
	assign rsp.r1 = mod255(sum1);

endmodule

// ===== rtl/gf256_lagrange_secret_recombine.sv =====
// gf256_lagrange_secret_recombine: top level, sequencer and storage of the recombine block
// depends on gflr_pkg, gflr_ram and gflr_unit
//
// usage
// - input channel (in_valid/in_stall): each transaction loads one share byte into
//   slot/byte_index and sets the share number of that slot; one transaction per cycle
//   while loading. a transaction with last set is loaded and then starts extraction.
// - during extraction in_stall is high. first the lagrange weight of every slot is
//   formed in the log domain by the shared unit, one slot pair at a time, bound by the
//   single read port of the slot number ram.
// - then each secret byte is formed slot by slot (share read, log add, antilog xor),
//   bound by the share ram read port; secret_size output transactions follow, the
//   last one marked by final_res. a registered clear then marks all slots empty.
// - output channel (out_valid/out_stall): a result sits in an output register; while
//   out_stall holds it, the sequencer waits before placing the next byte.
// - configuration (cfg_we/cfg_index/cfg_data) must be written only while the block is
//   idle; the block itself does not enforce this.
// - reset empties all slots and sets slot_count to 16 and secret_size to 32;
//   share bytes are not cleared and must be loaded before they are used.
module gf256_lagrange_secret_recombine import gflr_pkg::*; #(
	parameter int MAX_SLOTS = 16,
	parameter int MAX_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          slot,
	input  logic [7:0]          share_x,
	input  logic [4:0]          byte_index,
	input  logic [7:0]          share_data,
	input  logic                last,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          secret_byte,
	output logic [INDEX_W-1:0]  out_index,
	output logic                final_res,
	// configuration
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [SIZE_W-1:0]   cfg_data
);

	localparam int SLOT_AW = $clog2(MAX_SLOTS);
	localparam int SH_AW   = $clog2(MAX_SLOTS * MAX_BYTES);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_START  = 12'b0000_0000_0010,
		S_W_XI   = 12'b0000_0000_0100,
		S_W_XI2  = 12'b0000_0000_1000,
		S_W_RD   = 12'b0000_0001_0000,
		S_W_ACC  = 12'b0000_0010_0000,
		S_W_FIN  = 12'b0000_0100_0000,
		S_B_INIT = 12'b0000_1000_0000,
		S_B_RD   = 12'b0001_0000_0000,
		S_B_MUL  = 12'b0010_0000_0000,
		S_B_XOR  = 12'b0100_0000_0000,
		S_B_PUT  = 12'b1000_0000_0000
	} state_t;

	state_t                 state_q;
	logic [SLOT_CNT_W-1:0]  slot_count_q;
	logic [SIZE_W-1:0]      secret_size_q;
	logic [MAX_SLOTS-1:0]   sn_valid_q;
	logic                   sn_rd_ok_q;
	logic [SLOT_CNT_W-1:0]  i_q;
	logic [SLOT_CNT_W-1:0]  j_q;
	logic [SIZE_W-1:0]      k_q;
	logic [7:0]             xi_q;
	logic [7:0]             top_q;
	logic [7:0]             bottom_q;
	logic [SH_AW-1:0]       sh_base_q;
	logic [7:0]             acc_q;
	logic                   hit_q;
	logic [7:0]             idx_q;
	logic                   out_valid_q;
	logic                   clear_q;
	logic [7:0]             secret_byte_q;
	logic [INDEX_W-1:0]     out_index_q;
	logic                   final_q;

	logic                   in_acc;
	logic                   slot_ok;
	logic                   byte_ok;
	logic [SLOT_CNT_W-1:0]  cnt_eff;
	logic [SIZE_W-1:0]      size_eff;
	logic                   i_end;
	logic                   j_end;
	logic                   k_end;
	logic                   out_free;
	logic                   put_now;
	logic [7:0]             x_now;

	logic [SLOT_AW-1:0]     sn_raddr;
	logic [7:0]             sn_rdata;
	logic                   wt_we;
	logic [8:0]             wt_wdata;
	logic [8:0]             wt_rdata;
	logic                   sh_we;
	logic [SH_AW-1:0]       sh_waddr;
	logic [SH_AW-1:0]       sh_raddr;
	logic [7:0]             sh_rdata;
	unit_req_t              ureq;
	unit_rsp_t              ursp;

	// handshake and range checks
	assign in_stall = (state_q != S_IDLE) || clear_q;
	assign in_acc   = in_valid && !in_stall;
	assign slot_ok  = 32'(slot) < MAX_SLOTS;
	assign byte_ok  = 32'(byte_index) < MAX_BYTES;

	// registers saturate at the storage limits
	assign cnt_eff  = (32'(slot_count_q) < MAX_SLOTS) ? slot_count_q : SLOT_CNT_W'(MAX_SLOTS);
	assign size_eff = (32'(secret_size_q) < MAX_BYTES) ? secret_size_q : SIZE_W'(MAX_BYTES);
	assign i_end    = (i_q + SLOT_CNT_W'(1)) == cnt_eff;
	assign j_end    = (j_q + SLOT_CNT_W'(1)) == cnt_eff;
	assign k_end    = (k_q + SIZE_W'(1)) == size_eff;

	assign out_free = !out_valid_q || !out_stall;
	assign put_now  = (state_q == S_B_PUT) && out_free;

	// slot number of the last read, an empty slot reads as zero
	assign x_now = sn_rd_ok_q ? sn_rdata : 8'h00;

	// slot number store
	assign sn_raddr = (state_q == S_W_RD) ? SLOT_AW'(j_q) : SLOT_AW'(i_q);

	gflr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (in_acc && slot_ok),
		.waddr (SLOT_AW'(slot)),
		.wdata (share_x),
		.raddr (sn_raddr),
		.rdata (sn_rdata)
	);

	// weight store: active flag and log of the weight
	assign wt_we    = ((state_q == S_W_XI2) && (x_now == 8'h00)) || (state_q == S_W_FIN);
	assign wt_wdata = (state_q == S_W_FIN) ? {1'b1, ursp.r0} : 9'h000;

	gflr_ram #(
		.WIDTH (9),
		.DEPTH (MAX_SLOTS)
	) u_weight_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (SLOT_AW'(i_q)),
		.wdata (wt_wdata),
		.raddr (SLOT_AW'(i_q)),
		.rdata (wt_rdata)
	);

	// share byte store, row per slot
	assign sh_we    = in_acc && slot_ok && byte_ok;
	assign sh_waddr = SH_AW'(32'(slot) * MAX_BYTES + 32'(byte_index));
	assign sh_raddr = sh_base_q + SH_AW'(k_q);

	gflr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_SLOTS * MAX_BYTES)
	) u_share_ram (
		.clk   (clk),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (share_data),
		.raddr (sh_raddr),
		.rdata (sh_rdata)
	);

	// shared log-domain unit operands
	always_comb begin
		ureq.op = UOP_PAIR;
		ureq.a  = top_q;
		ureq.b  = bottom_q;
		ureq.x  = x_now;
		ureq.y  = xi_q ^ x_now;
		case (state_q)
			S_W_FIN: begin
				ureq.op = UOP_DIFF;
			end
			S_B_MUL: begin
				ureq.op = UOP_MUL;
				ureq.a  = wt_rdata[7:0];
				ureq.x  = sh_rdata;
			end
			default: begin
				ureq.op = UOP_PAIR;
			end
		endcase
	end

	gflr_unit u_unit (
		.req (ureq),
		.rsp (ursp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q  <= SLOT_CNT_W'(16);
			secret_size_q <= SIZE_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SLOT_COUNT:  slot_count_q  <= cfg_data[SLOT_CNT_W-1:0];
				CFG_SECRET_SIZE: secret_size_q <= cfg_data;
				default:         slot_count_q  <= slot_count_q;
			endcase
		end
	end

	// slot valid bits, set on load and cleared after each run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sn_valid_q <= '0;
			sn_rd_ok_q <= 1'b0;
		end else begin
			sn_rd_ok_q <= sn_valid_q[sn_raddr];
			if (clear_q) begin
				sn_valid_q <= '0;
			end else if (in_acc && slot_ok) begin
				sn_valid_q[SLOT_AW'(slot)] <= 1'b1;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put_now) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (put_now) begin
			secret_byte_q <= acc_q;
			out_index_q   <= k_q[INDEX_W-1:0];
			final_q       <= k_end;
		end
	end

	// sequencer: weight pass over slot pairs, then one byte at a time over slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clear_q   <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			xi_q      <= '0;
			top_q     <= '0;
			bottom_q  <= '0;
			sh_base_q <= '0;
			acc_q     <= '0;
			hit_q     <= 1'b0;
			idx_q     <= '0;
		end else begin
			clear_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && last) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					i_q     <= '0;
					state_q <= (cnt_eff != '0) ? S_W_XI : S_B_INIT;
				end
				S_W_XI: begin
					state_q <= S_W_XI2;
				end
				S_W_XI2: begin
					xi_q     <= x_now;
					top_q    <= '0;
					bottom_q <= '0;
					j_q      <= '0;
					if (x_now != 8'h00) begin
						state_q <= S_W_RD;
					end else begin
						i_q     <= i_q + SLOT_CNT_W'(1);
						state_q <= i_end ? S_B_INIT : S_W_XI;
					end
				end
				S_W_RD: begin
					state_q <= S_W_ACC;
				end
				S_W_ACC: begin
					// skip self, equal numbers and empty slots
					if ((j_q != i_q) && (x_now != xi_q) && (x_now != 8'h00)) begin
						top_q    <= ursp.r0;
						bottom_q <= ursp.r1;
					end
					j_q     <= j_q + SLOT_CNT_W'(1);
					state_q <= j_end ? S_W_FIN : S_W_RD;
				end
				S_W_FIN: begin
					i_q     <= i_q + SLOT_CNT_W'(1);
					state_q <= i_end ? S_B_INIT : S_W_XI;
				end
				S_B_INIT: begin
					k_q       <= '0;
					i_q       <= '0;
					sh_base_q <= '0;
					acc_q     <= '0;
					if (size_eff == '0) begin
						clear_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= (cnt_eff != '0) ? S_B_RD : S_B_PUT;
					end
				end
				S_B_RD: begin
					state_q <= S_B_MUL;
				end
				S_B_MUL: begin
					hit_q   <= wt_rdata[8] && (sh_rdata != 8'h00);
					idx_q   <= ursp.r0;
					state_q <= S_B_XOR;
				end
				S_B_XOR: begin
					if (hit_q) begin
						acc_q <= acc_q ^ GF_EXP[idx_q];
					end
					i_q       <= i_q + SLOT_CNT_W'(1);
					sh_base_q <= sh_base_q + SH_AW'(MAX_BYTES);
					state_q   <= i_end ? S_B_PUT : S_B_RD;
				end
				S_B_PUT: begin
					if (out_free) begin
						k_q       <= k_q + SIZE_W'(1);
						i_q       <= '0;
						sh_base_q <= '0;
						acc_q     <= '0;
						if (k_end) begin
							clear_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= (cnt_eff != '0) ? S_B_RD : S_B_PUT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign secret_byte = secret_byte_q;
	assign out_index   = out_index_q;
	assign final_res   = final_q;

endmodule
